@@ hdl/utf8d_pkg.sv @@
// Shared types, constants and lead byte classification for the UTF-8 decoder.
package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 31;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned CONT_W = 6;

    localparam logic [BYTE_W-1:0] MASK_LEN2 = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_LEN3 = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_LEN4 = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_LEN5 = 8'h03;
    localparam logic [BYTE_W-1:0] MASK_LEN6 = 8'h01;
    localparam logic [BYTE_W-1:0] MASK_ALL  = 8'hFF;

    // Sequence length and payload mask implied by a lead byte.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] mask;
    } lead_class_t;

    // One decoded character leaving the decode core.
    typedef struct packed {
        logic              vld;
        logic [CP_W-1:0]   code_point;
        logic [LEN_W-1:0]  seq_length;
    } result_t;

    function automatic lead_class_t lead_class(input logic [BYTE_W-1:0] b);
        lead_class_t lc;
        lc.len  = 3'd1;
        lc.mask = MASK_ALL;
        if (b inside {[8'hC0:8'hDF]})
        begin
            lc.len  = 3'd2;
            lc.mask = MASK_LEN2;
        end
        else if (b inside {[8'hE0:8'hEF]})
        begin
            lc.len  = 3'd3;
            lc.mask = MASK_LEN3;
        end
        else if (b inside {[8'hF0:8'hF7]})
        begin
            lc.len  = 3'd4;
            lc.mask = MASK_LEN4;
        end
        else if (b inside {[8'hF8:8'hFB]})
        begin
            lc.len  = 3'd5;
            lc.mask = MASK_LEN5;
        end
        else if (b inside {[8'hFC:8'hFD]})
        begin
            lc.len  = 3'd6;
            lc.mask = MASK_LEN6;
        end
        return lc;
    endfunction

endpackage

@@ hdl/utf8d_core.sv @@
// Decode core: sequence state registers and the per-byte update logic.
module utf8d_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [utf8d_pkg::BYTE_W-1:0]  byte_in,
    input  logic                          start,
    output utf8d_pkg::result_t            res
);
    import utf8d_pkg::*;

    logic [LEN_W-1:0] pending_reg, pending_next;
    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;

    logic [LEN_W-1:0] pend_eff;
    logic [CP_W-1:0]  acc_eff;
    logic [LEN_W-1:0] len_eff;
    logic [CP_W-1:0]  acc_shift;
    lead_class_t      lc;

    always_comb
    begin
        // A string start drops any unfinished sequence before this byte.
        pend_eff  = start ? '0 : pending_reg;
        acc_eff   = start ? '0 : acc_reg;
        len_eff   = start ? '0 : cur_len_reg;
        lc        = lead_class(byte_in);
        acc_shift = {acc_eff[CP_W-CONT_W-1:0], byte_in[CONT_W-1:0]};

        pending_next   = pending_reg;
        acc_next       = acc_reg;
        cur_len_next   = cur_len_reg;
        res.vld        = 1'b0;
        res.code_point = '0;
        res.seq_length = '0;

        if (fire)
        begin
            if (pend_eff == '0)
            begin
                if (lc.len == 3'd1)
                begin
                    res.vld        = 1'b1;
                    res.code_point = CP_W'(byte_in & lc.mask);
                    res.seq_length = 3'd1;
                    pending_next   = '0;
                    acc_next       = '0;
                    cur_len_next   = '0;
                end
                else
                begin
                    acc_next     = CP_W'(byte_in & lc.mask);
                    cur_len_next = lc.len;
                    pending_next = lc.len - 3'd1;
                end
            end
            else
            begin
                pending_next = pend_eff - 3'd1;
                if (pend_eff == 3'd1)
                begin
                    res.vld        = 1'b1;
                    res.code_point = acc_shift;
                    res.seq_length = len_eff;
                    acc_next       = '0;
                    cur_len_next   = '0;
                end
                else
                begin
                    acc_next     = acc_shift;
                    cur_len_next = len_eff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            acc_reg     <= '0;
            cur_len_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            cur_len_reg <= cur_len_next;
        end
    end

endmodule

@@ hdl/utf8_to_code_point_decoder_top.sv @@
// Top level of the six-byte UTF-8 to code point decoder.
// This block takes one byte of UTF-8 text per transfer and, when a byte
// completes a character, delivers one transfer with the 31-bit code point and
// the number of bytes it used (1 to 6, the original six-byte form). Bytes that
// cannot start a sequence (stray continuation bytes, 0xFE and 0xFF) come out
// as one-byte characters with the byte value as code point. Continuation bytes
// give their low six bits without any check of their top bits. Raising
// string_start with a byte drops an unfinished sequence silently, and that
// byte is decoded as a lead byte. The block sustains one byte per clock cycle
// while out_stall is low: a byte is captured in an input register, decoded in
// one pass through the decode core (a mask or a six-bit shift), and the result
// of a completed character is registered in an output register. The output
// register and the input register together let a new byte enter while a
// finished result still waits for the downstream side; only a stalled output
// with a byte already waiting in the input register holds in_stall high.
module utf8_to_code_point_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [utf8d_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          string_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [utf8d_pkg::CP_W-1:0]    code_point,
    output logic [utf8d_pkg::LEN_W-1:0]   seq_length
);
    import utf8d_pkg::*;

    // Input register.
    logic              in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;

    // Output register.
    logic              out_vld_reg, out_vld_next;
    logic [CP_W-1:0]   out_cp_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic    in_accept;
    logic    advance;
    result_t res;

    // The held byte is decoded when the output register is free or is being
    // emptied in this same cycle.
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = res.vld;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    utf8d_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .byte_in (in_byte_reg),
        .start   (in_start_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg  <= in_byte;
            in_start_reg <= string_start;
        end
        if (advance && res.vld)
        begin
            out_cp_reg  <= res.code_point;
            out_len_reg <= res.seq_length;
        end
    end

    assign out_valid  = out_vld_reg;
    assign code_point = out_cp_reg;
    assign seq_length = out_len_reg;

    // A held result that is stalled must never be overwritten by a decode.
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |-> !advance)
        else $error("decode advanced over a stalled result");

    // Every result the core produces has a length from one to six.
    a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.vld) |-> (res.seq_length != 3'd0 && res.seq_length <= 3'd6))
        else $error("result length out of range");

    // A one-byte character never carries more than eight bits of value.
    a_single_byte : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.vld && res.seq_length == 3'd1)
            |-> (res.code_point[CP_W-1:BYTE_W] == '0))
        else $error("one-byte character with wide code point");

    // A byte waiting in the input register is decoded in any cycle in which the output register is empty.
    a_progress : assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_vld_reg) |-> advance)
        else $error("held byte not decoded while output register is empty");

endmodule
